// ----- design/scaled_glyph_framebuffer_renderer_assert.svh -----
// ----------------------------------------------------------------------------
// scaled glyph framebuffer renderer assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_FRAMEBUFFER_RENDERER_ASSERT_SVH
`define SCALED_GLYPH_FRAMEBUFFER_RENDERER_ASSERT_SVH
`ifndef SYNTHESIS
`define SGFR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SGFR_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SGFR_ASSERT(name, clk, rst, prop, msg)
`define SGFR_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`endif
`endif

// ----- design/sgfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sgfr_pkg
// shared constants, glyph rom, controller states and command/status structs
// ----------------------------------------------------------------------------
`default_nettype none

package sgfr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COUNT = 37;
  localparam int SCALE_W     = 4;
  localparam int INDEX_W     = 10;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

  // digits, colon, then A-Z; bit n of a column byte is glyph row n
  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
    '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
    '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
    '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
    '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ,
    ST_COL,
    ST_STEP,
    ST_FL_RD,
    ST_FL_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic pix_rd;
    logic pix_wr;
    logic byte_rd;
    logic col_start;
    logic col_next;
    logic step;
    logic fl_rd;
    logic fl_wr;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       draw_ok;
    logic       pix_ok;
    logic       clear_last;
    logic       col_draw;
    logic       last_col;
    logic       last_step;
    logic       flush_need;
    logic       flush_last;
    logic       out_free;
  } dp_stat_t;

  function automatic logic glyph_valid(input logic [7:0] code);
    return (code >= 8'h30 && code <= 8'h39) || code == 8'h3A ||
           (code >= 8'h41 && code <= 8'h5A) || (code >= 8'h61 && code <= 8'h7A);
  endfunction

  // lowercase folds onto the uppercase rows
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [5:0] idx;
    idx = 6'd0;
    if (code >= 8'h30 && code <= 8'h39) begin
      idx = 6'(code - 8'h30);
    end else if (code == 8'h3A) begin
      idx = 6'd10;
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      idx = 6'(code - 8'h41 + 8'd11);
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      idx = 6'(code - 8'h61 + 8'd11);
    end
    return idx;
  endfunction

  function automatic logic [7:0] glyph_column(input logic [5:0] idx, input logic [2:0] col);
    logic [7:0] bits;
    bits = 8'h00;
    if (32'(idx) < GLYPH_COUNT && 32'(col) < GLYPH_COLS) begin
      bits = GLYPH_ROM[idx][col];
    end
    return bits;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [4:0] page, input logic [7:0] x);
    return ADDR_W'(32'(page) * SCREEN_WIDTH + 32'(x));
  endfunction

endpackage

`default_nettype wire

// ----- design/sgfr_dp.sv -----
// ----------------------------------------------------------------------------
// sgfr_dp
// framebuffer memory, operand registers, glyph scan counters, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "scaled_glyph_framebuffer_renderer_assert.svh"

module sgfr_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  sgfr_pkg::dp_cmd_t        cmd,
  output sgfr_pkg::dp_stat_t       stat,
  input  logic [1:0]               in_opcode,
  input  logic [7:0]               in_x,
  input  logic [7:0]               in_y,
  input  logic [7:0]               in_code,
  input  logic [sgfr_pkg::INDEX_W-1:0] in_index,
  input  logic                     cfg_valid,
  input  logic [sgfr_pkg::SCALE_W-1:0] cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [7:0]               out_data,
  output logic                     out_flag
);

  logic [7:0] mem [sgfr_pkg::STORE_BYTES];

  logic [sgfr_pkg::SCALE_W-1:0] glyph_scale;
  logic [1:0]                   op_r;
  logic [7:0]                   x_r;
  logic [7:0]                   y_r;
  logic [7:0]                   code_r;
  logic [sgfr_pkg::INDEX_W-1:0] index_r;

  logic [sgfr_pkg::ADDR_W-1:0]  clr_cnt;
  logic [2:0]                   col_cnt;
  logic [sgfr_pkg::SCALE_W-1:0] sx_cnt;
  logic [7:0]                   px;
  logic [2:0]                   row_cnt;
  logic [sgfr_pkg::SCALE_W-1:0] sy_cnt;
  logic [7:0]                   py;
  logic [7:0]                   acc;
  logic [sgfr_pkg::ADDR_W-1:0]  flush_addr;
  logic                         flush_last;
  logic [7:0]                   rdata;

  logic [sgfr_pkg::SCALE_W-1:0] scale_m1;
  logic [7:0]                   col_bits;
  logic                         lit;
  logic [7:0]                   acc_next;
  logic                         row_end;
  logic                         last_step;
  logic                         page_end;
  logic                         last_col;
  logic                         index_ok;
  logic [sgfr_pkg::ADDR_W-1:0]  pix_addr;
  logic [7:0]                   pix_mask;
  logic                         out_free;

  logic                         mem_we;
  logic [sgfr_pkg::ADDR_W-1:0]  wr_addr;
  logic [7:0]                   wr_data;
  logic                         rd_en;
  logic [sgfr_pkg::ADDR_W-1:0]  rd_addr;

  assign scale_m1  = glyph_scale - 4'd1;
  assign col_bits  = sgfr_pkg::glyph_valid(code_r) ?
                     sgfr_pkg::glyph_column(sgfr_pkg::glyph_index(code_r), col_cnt) : 8'h00;
  assign lit       = col_bits[row_cnt] && (py < 8'(sgfr_pkg::SCREEN_HEIGHT));
  assign acc_next  = acc | (lit ? (8'h01 << py[2:0]) : 8'h00);
  assign row_end   = (sy_cnt == scale_m1);
  assign last_step = (row_cnt == 3'(sgfr_pkg::GLYPH_ROWS - 1)) && row_end;
  // a byte is done when the scan leaves its page or the column ends
  assign page_end  = (py[2:0] == 3'd7) || last_step;
  assign last_col  = (col_cnt == 3'(sgfr_pkg::GLYPH_COLS - 1)) && (sx_cnt == scale_m1);
  assign index_ok  = 32'(index_r) < sgfr_pkg::STORE_BYTES;
  assign pix_addr  = sgfr_pkg::byte_addr(y_r[7:3], x_r);
  assign pix_mask  = 8'h01 << y_r[2:0];
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    stat.op         = op_r;
    stat.draw_ok    = sgfr_pkg::glyph_valid(code_r) && (glyph_scale != '0);
    stat.pix_ok     = (x_r < 8'(sgfr_pkg::SCREEN_WIDTH)) &&
                      (y_r < 8'(sgfr_pkg::SCREEN_HEIGHT));
    stat.clear_last = (32'(clr_cnt) == sgfr_pkg::STORE_BYTES - 1);
    stat.col_draw   = (px < 8'(sgfr_pkg::SCREEN_WIDTH)) && (col_bits != 8'h00);
    stat.last_col   = last_col;
    stat.last_step  = last_step;
    stat.flush_need = page_end && (acc_next != 8'h00);
    stat.flush_last = flush_last;
    stat.out_free   = out_free;
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_cnt;
    wr_data = 8'h00;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.pix_wr) begin
      mem_we  = 1'b1;
      wr_addr = pix_addr;
      wr_data = rdata | pix_mask;
    end else if (cmd.fl_wr) begin
      mem_we  = 1'b1;
      wr_addr = flush_addr;
      wr_data = rdata | acc;
    end
  end

  always_comb begin
    rd_en   = cmd.pix_rd || cmd.fl_rd || cmd.byte_rd;
    rd_addr = flush_addr;
    if (cmd.pix_rd) begin
      rd_addr = pix_addr;
    end else if (cmd.byte_rd) begin
      rd_addr = sgfr_pkg::ADDR_W'(index_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_scale <= sgfr_pkg::SCALE_RESET;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        glyph_scale <= cfg_data;
      end
      if (cmd.load || (cmd.clr_step && stat.clear_last)) begin
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // operands, scan counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      x_r     <= in_x;
      y_r     <= in_y;
      code_r  <= in_code;
      index_r <= in_index;
      px      <= in_x;
      col_cnt <= '0;
      sx_cnt  <= '0;
    end
    if (cmd.col_next) begin
      px <= px + 8'd1;
      if (sx_cnt == scale_m1) begin
        sx_cnt  <= '0;
        col_cnt <= col_cnt + 3'd1;
      end else begin
        sx_cnt <= sx_cnt + 1'b1;
      end
    end
    if (cmd.col_start) begin
      row_cnt <= '0;
      sy_cnt  <= '0;
      py      <= y_r;
      acc     <= 8'h00;
    end else if (cmd.step) begin
      acc <= acc_next;
      py  <= py + 8'd1;
      if (row_end) begin
        sy_cnt  <= '0;
        row_cnt <= row_cnt + 3'd1;
      end else begin
        sy_cnt <= sy_cnt + 1'b1;
      end
      if (page_end) begin
        flush_addr <= sgfr_pkg::byte_addr(py[7:3], px);
        flush_last <= last_step;
      end
    end else if (cmd.fl_wr) begin
      acc <= 8'h00;
    end
    if (cmd.res_load) begin
      out_data <= (op_r == sgfr_pkg::OP_READ && index_ok) ? rdata : 8'h00;
      out_flag <= (op_r == sgfr_pkg::OP_READ);
    end
  end

  `SGFR_ASSERT_IMPL(a_wr_in_store, clk, rst, mem_we, 32'(wr_addr) < sgfr_pkg::STORE_BYTES, "write beyond store")
  `SGFR_ASSERT_IMPL(a_scan_on_screen, clk, rst, cmd.step, px < 8'(sgfr_pkg::SCREEN_WIDTH), "scan of off-screen column")

endmodule

`default_nettype wire

// ----- design/sgfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgfr_ctrl
// operation sequencer: clear sweep, pixel and byte access, glyph column scan
// ----------------------------------------------------------------------------
`default_nettype none

`include "scaled_glyph_framebuffer_renderer_assert.svh"

module sgfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgfr_pkg::dp_stat_t  stat,
  output sgfr_pkg::dp_cmd_t   cmd
);

  sgfr_pkg::state_t state;
  sgfr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgfr_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sgfr_pkg::ST_INIT: begin
        if (stat.clear_last) state_next = sgfr_pkg::ST_IDLE;
      end
      sgfr_pkg::ST_IDLE: begin
        if (in_valid) state_next = sgfr_pkg::ST_DISPATCH;
      end
      sgfr_pkg::ST_DISPATCH: begin
        case (stat.op)
          sgfr_pkg::OP_CLEAR: state_next = sgfr_pkg::ST_CLEAR;
          sgfr_pkg::OP_DRAW:
            state_next = stat.draw_ok ? sgfr_pkg::ST_COL : sgfr_pkg::ST_DONE;
          sgfr_pkg::OP_PIXEL:
            state_next = stat.pix_ok ? sgfr_pkg::ST_PIX_RD : sgfr_pkg::ST_DONE;
          default: state_next = sgfr_pkg::ST_READ;
        endcase
      end
      sgfr_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = sgfr_pkg::ST_DONE;
      end
      sgfr_pkg::ST_PIX_RD: state_next = sgfr_pkg::ST_PIX_WR;
      sgfr_pkg::ST_PIX_WR: state_next = sgfr_pkg::ST_DONE;
      sgfr_pkg::ST_READ:   state_next = sgfr_pkg::ST_DONE;
      sgfr_pkg::ST_COL: begin
        if (stat.col_draw) begin
          state_next = sgfr_pkg::ST_STEP;
        end else if (stat.last_col) begin
          state_next = sgfr_pkg::ST_DONE;
        end
      end
      sgfr_pkg::ST_STEP: begin
        if (stat.flush_need) begin
          state_next = sgfr_pkg::ST_FL_RD;
        end else if (stat.last_step) begin
          state_next = stat.last_col ? sgfr_pkg::ST_DONE : sgfr_pkg::ST_COL;
        end
      end
      sgfr_pkg::ST_FL_RD: state_next = sgfr_pkg::ST_FL_WR;
      sgfr_pkg::ST_FL_WR: begin
        if (!stat.flush_last) begin
          state_next = sgfr_pkg::ST_STEP;
        end else begin
          state_next = stat.last_col ? sgfr_pkg::ST_DONE : sgfr_pkg::ST_COL;
        end
      end
      sgfr_pkg::ST_DONE: begin
        if (stat.out_free) state_next = sgfr_pkg::ST_IDLE;
      end
      default: state_next = sgfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      sgfr_pkg::ST_INIT:  cmd.clr_step = 1'b1;
      sgfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sgfr_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      sgfr_pkg::ST_PIX_RD: cmd.pix_rd   = 1'b1;
      sgfr_pkg::ST_PIX_WR: cmd.pix_wr   = 1'b1;
      sgfr_pkg::ST_READ:   cmd.byte_rd  = 1'b1;
      sgfr_pkg::ST_COL: begin
        cmd.col_start = stat.col_draw;
        cmd.col_next  = !stat.col_draw;
      end
      sgfr_pkg::ST_STEP: begin
        cmd.step     = 1'b1;
        // column finished with nothing left to write back
        cmd.col_next = stat.last_step && !stat.flush_need;
      end
      sgfr_pkg::ST_FL_RD: cmd.fl_rd = 1'b1;
      sgfr_pkg::ST_FL_WR: begin
        cmd.fl_wr    = 1'b1;
        cmd.col_next = stat.flush_last;
      end
      sgfr_pkg::ST_DONE: cmd.res_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

  `SGFR_ASSERT_IMPL(a_res_slot_free, clk, rst, cmd.res_load, stat.out_free, "result loaded over pending result")
  `SGFR_ASSERT_IMPL(a_flush_order, clk, rst, state == sgfr_pkg::ST_FL_WR, $past(state) == sgfr_pkg::ST_FL_RD, "write-back without read")

endmodule

`default_nettype wire

// ----- design/scaled_glyph_framebuffer_renderer.sv -----
// ----------------------------------------------------------------------------
// scaled_glyph_framebuffer_renderer
// clear writes one byte per cycle; draw scales glyphs by glyph_scale and
// writes each touched byte back by read-modify-write of the framebuffer memory
// one operation at a time; the result register frees the input side early
// after reset a clearing pass over all 1024 bytes runs with s_axis_tready low
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_framebuffer_renderer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // pos_x, pos_y, char_code, byte_index, zero pad
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // read_data
  output logic        m_axis_tuser,  // read_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data       // glyph_scale
);

  sgfr_pkg::dp_cmd_t  cmd;
  sgfr_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sgfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sgfr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_opcode (s_axis_tuser),
    .in_x      (s_axis_tdata[7:0]),
    .in_y      (s_axis_tdata[15:8]),
    .in_code   (s_axis_tdata[23:16]),
    .in_index  (s_axis_tdata[33:24]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser)
  );

endmodule

`default_nettype wire
